### hdl/t2a_pkg.sv
`default_nettype none
// ============================================================================
// t2a_pkg: shared types and constants of the tenths-to-ASCII formatter
// Holds the ASCII codes, the byte selector and the command/status structs
// that pass between the controller and the datapath.
// ============================================================================
package t2a_pkg;

    // Widths of the input value and of one output byte
    localparam int VALUE_W  = 16;
    localparam int CHAR_W   = 8;

    // Decimal digits kept: tenths plus up to four whole digits
    localparam int NUM_DIGITS = 5;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int DIGIT_W    = 4;

    // Reciprocal of ten scaled by 2^19, exact for every 16-bit magnitude
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);
    localparam int QUOT_W      = VALUE_W - 3;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_C     = 8'h43;
    localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h0A;

    // Which byte the datapath loads into the output register
    typedef enum logic [2:0] {
        SEL_SIGN,
        SEL_DIGIT,
        SEL_POINT,
        SEL_C,
        SEL_CR,
        SEL_LF
    } t_byte_sel;

    // Controller to datapath
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 emit;
        t_byte_sel            sel;
        logic [DIG_IDX_W-1:0] idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                 negative;
        logic                 out_free;
        logic [DIG_IDX_W-1:0] top_idx;
    } t_sts;

endpackage
`default_nettype wire

### hdl/t2a_datapath.sv
`default_nettype none
// ============================================================================
// t2a_datapath: magnitude, digit registers and output byte register
// Splits the magnitude into decimal digits one divide-by-ten per step and
// builds each output byte on command from the controller.
// ============================================================================
module t2a_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [t2a_pkg::VALUE_W-1:0]   i_tenths_value,
    input  wire t2a_pkg::t_cmd                 i_cmd,
    output t2a_pkg::t_sts                      o_sts,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [t2a_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_end_of_run
);
    import t2a_pkg::*;

    logic [VALUE_W-1:0]         r_rem;
    logic                       r_neg;
    logic [DIGIT_W-1:0]         r_dig [NUM_DIGITS];
    logic                       r_out_valid;
    logic [CHAR_W-1:0]          r_char;
    logic                       r_last;

    logic [VALUE_W-1:0]         n_mag;
    logic [VALUE_W+RECIP_W-1:0] w_prod;
    logic [QUOT_W-1:0]          w_quot;
    logic [VALUE_W-1:0]         w_times_ten;
    logic [VALUE_W-1:0]         w_diff;
    logic [DIGIT_W-1:0]         w_sel_dig;
    logic [CHAR_W-1:0]          n_char;
    logic [DIG_IDX_W-1:0]       w_top;

    // Magnitude of the signed input; the most negative value maps to 32768
    assign n_mag = i_tenths_value[VALUE_W-1] ? (~i_tenths_value + VALUE_W'(1))
                                             : i_tenths_value;

    // Divide by ten through the scaled reciprocal, remainder by shift-add
    assign w_prod      = r_rem * RECIP_TEN;
    assign w_quot      = w_prod[RECIP_SHIFT +: QUOT_W];
    assign w_times_ten = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_diff      = r_rem - w_times_ten;

    // Load the magnitude, then shift one digit in per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= n_mag;
            r_neg <= i_tenths_value[VALUE_W-1];
        end else if (i_cmd.step) begin
            r_rem <= VALUE_W'(w_quot);
            for (int k = 0; k < NUM_DIGITS - 1; k++) begin
                r_dig[k] <= r_dig[k+1];
            end
            r_dig[NUM_DIGITS-1] <= w_diff[DIGIT_W-1:0];
        end
    end

    // Highest nonzero whole digit, at least the ones digit
    always_comb begin
        w_top = DIG_IDX_W'(1);
        for (int k = 2; k < NUM_DIGITS; k++) begin
            if (r_dig[k] != '0) begin
                w_top = DIG_IDX_W'(k);
            end
        end
    end

    // Pick the next byte
    assign w_sel_dig = (i_cmd.idx < DIG_IDX_W'(NUM_DIGITS)) ? r_dig[i_cmd.idx] : '0;

    always_comb begin
        case (i_cmd.sel)
            SEL_SIGN:  n_char = ASCII_MINUS;
            SEL_DIGIT: n_char = ASCII_ZERO + CHAR_W'(w_sel_dig);
            SEL_POINT: n_char = ASCII_POINT;
            SEL_C:     n_char = ASCII_C;
            SEL_CR:    n_char = ASCII_CR;
            SEL_LF:    n_char = ASCII_LF;
            default:   n_char = ASCII_LF;
        endcase
    end

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= (i_cmd.sel == SEL_LF);
        end
    end

    assign o_sts.negative = r_neg;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.top_idx  = w_top;

    assign o_out_valid  = r_out_valid;
    assign o_character  = r_char;
    assign o_end_of_run = r_last;

endmodule
`default_nettype wire

### hdl/t2a_ctrl.sv
`default_nettype none
// ============================================================================
// t2a_ctrl: sequencing state machine of the formatter
// Accepts an item, runs the digit steps, then walks the text of the run
// byte by byte as the output register frees up.
// ============================================================================
module t2a_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t2a_pkg::t_sts i_sts,
    output t2a_pkg::t_cmd      o_cmd
);
    import t2a_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_WHOLE,
        S_POINT,
        S_TENTH,
        S_UNIT,
        S_CR,
        S_LF
    } t_state;

    t_state               r_state, n_state;
    logic [DIG_IDX_W-1:0] r_cnt, n_cnt;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.sel  = SEL_DIGIT;
        o_cmd.idx  = r_cnt;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + DIG_IDX_W'(1);
                if (r_cnt == DIG_IDX_W'(NUM_DIGITS - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                o_cmd.sel = SEL_SIGN;
                if (!i_sts.negative) begin
                    n_cnt   = i_sts.top_idx;
                    n_state = S_WHOLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = i_sts.top_idx;
                    n_state    = S_WHOLE;
                end
            end
            S_WHOLE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = r_cnt - DIG_IDX_W'(1);
                    if (r_cnt == DIG_IDX_W'(1)) begin
                        n_state = S_POINT;
                    end
                end
            end
            S_POINT: begin
                o_cmd.sel = SEL_POINT;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_TENTH;
                end
            end
            S_TENTH: begin
                o_cmd.idx = '0;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_UNIT;
                end
            end
            S_UNIT: begin
                o_cmd.sel = SEL_C;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_CR;
                end
            end
            S_CR: begin
                o_cmd.sel = SEL_CR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LF;
                end
            end
            S_LF: begin
                o_cmd.sel = SEL_LF;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and digit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/tenths_to_ascii_formatter.sv
`default_nettype none
// Order: an accepted item first runs through the digit steps; the first byte then
//   registered is the minus sign for a negative value, otherwise the leading digit.
// Run: five divide-by-ten steps through one shared reciprocal multiplier form the
//   digits, then 6 to 10 bytes follow, one output byte per cycle while the output
//   does not stall; a new item is taken only once the line feed has been emitted.
// Reset: synchronous, active low; clears the state machine and the output valid.
// ============================================================================
// tenths_to_ascii_formatter: signed tenths value to ASCII text run
// Prints an optional minus sign, the whole part, a point, the tenths digit
// and "C\r\n", marking the line feed as the end of the run.
// ============================================================================
module tenths_to_ascii_formatter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [t2a_pkg::VALUE_W-1:0] i_tenths_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [t2a_pkg::CHAR_W-1:0]       o_character,
    output logic                             o_end_of_run
);
    import t2a_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    t2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    t2a_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tenths_value (i_tenths_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_character    (o_character),
        .o_end_of_run   (o_end_of_run)
    );

    // Busy after an accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("formatter accepted an item while a run was in progress");

    // Only the final byte of a run may still wait once the block is idle
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && o_out_valid) |-> o_end_of_run)
        else $error("idle with a byte other than the line feed pending");

    // The end mark rides on the line feed only
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_end_of_run == (o_character == ASCII_LF)))
        else $error("end of run mark not aligned with the line feed");

    // Nothing is emitted during the digit steps
    a_no_emit_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_cmd.emit)
        else $error("byte emitted while digits were still being formed");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the tenths-to-ASCII formatter
// Feeds signed tenths values through the input channel, predicts the ASCII
// run of each accepted item and checks every output byte and its end-of-run
// flag in order. Both channels idle and stall at random, and the output is
// held off for long stretches so that the block fills up and stalls its input.
// ============================================================================
module tb_top;
    import t2a_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 385;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ROUNDS   = 2;
    localparam int REPORT_LIMIT  = 10;

    // One expected output byte
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_byte;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [VALUE_W-1:0]  i_tenths_value = '0;
    logic                i_out_stall    = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [CHAR_W-1:0]   o_character;
    logic                o_end_of_run;

    logic [VALUE_W-1:0]  pending_values [$];
    t_text_byte          expected_text [$];
    int                  items_taken    = 0;
    int                  cycle_count    = 0;
    int                  hold_left      = 0;
    int                  hold_rounds    = 0;
    int                  send_gap       = 0;
    int                  stall_left     = 0;
    int                  fail_count     = 0;
    logic                calm;

    tenths_to_ascii_formatter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_tenths_value (i_tenths_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_end_of_run   (o_end_of_run)
    );

    // Stretches with no idling on either side
    assign calm = (cycle_count[11:10] == 2'b01);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, a few long
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Build the text run of one value: sign, whole digits, point, tenths, "C\r\n"
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic              negative;
        logic [VALUE_W:0]  magnitude;
        int unsigned       whole;
        int unsigned       tenth;
        int                n_digits;
        logic [CHAR_W-1:0] digit_chars [NUM_DIGITS];
        negative  = value[VALUE_W-1];
        magnitude = negative ? ((VALUE_W+1)'(1) << VALUE_W) - {1'b0, value}
                             : {1'b0, value};
        whole     = magnitude / 10;
        tenth     = magnitude % 10;
        n_digits  = 0;
        do begin
            digit_chars[n_digits] = ASCII_ZERO + CHAR_W'(whole % 10);
            n_digits++;
            whole = whole / 10;
        end while (whole > 0 && n_digits < NUM_DIGITS);
        if (negative)
            expected_text.push_back(t_text_byte'{ASCII_MINUS, 1'b0});
        for (int k = n_digits - 1; k >= 0; k--)
            expected_text.push_back(t_text_byte'{digit_chars[k], 1'b0});
        expected_text.push_back(t_text_byte'{ASCII_POINT, 1'b0});
        expected_text.push_back(t_text_byte'{ASCII_ZERO + CHAR_W'(tenth), 1'b0});
        expected_text.push_back(t_text_byte'{ASCII_C, 1'b0});
        expected_text.push_back(t_text_byte'{ASCII_CR, 1'b0});
        expected_text.push_back(t_text_byte'{ASCII_LF, 1'b1});
    endfunction

    // Fill the item queue, release reset, wait for drain and report
    initial begin
        logic [VALUE_W-1:0] magnitude;
        int                 directed [] = '{0, 1, 5, 9, 10, 99, 100, 999, 1000, 9999,
                                            10000, 12345, 32767, -1, -5, -9, -10,
                                            -11, -99, -100, -9999, -10000, -12345,
                                            -32767, -32768};
        foreach (directed[k])
            pending_values.push_back(VALUE_W'(directed[k]));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 2))
                0: pending_values.push_back(VALUE_W'($urandom));
                1: pending_values.push_back(VALUE_W'($urandom_range(0, 240)) - VALUE_W'(120));
                default: begin
                    // spread over every digit count of the whole part
                    magnitude = VALUE_W'($urandom_range(0, 32767) >> $urandom_range(0, 14));
                    pending_values.push_back($urandom_range(0, 1) ? -magnitude : magnitude);
                end
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() > 0 || i_in_valid || expected_text.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_text.size() > 0)
            fail_count = fail_count + 1;
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Input driver: hold while stalled, otherwise advance after a random gap
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_text(i_tenths_value);
                items_taken <= items_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 && hold_left == 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_values.size() > 0) begin
                    i_tenths_value <= pending_values.pop_front();
                    i_in_valid     <= 1'b1;
                    send_gap = calm ? 0 : idle_length();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, started twice once items are flowing
    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_rounds < HOLD_ROUNDS && items_taken >= 60 + 200 * hold_rounds) begin
            hold_left   <= HOLD_CYCLES;
            hold_rounds <= hold_rounds + 1;
        end
    end

    // Output stall: random stretches plus the hold-off
    always @(posedge i_clk) begin
        logic stall_now;
        int   len;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            stall_now  = 1'b1;
        end else begin
            len        = calm ? 0 : idle_length();
            stall_now  = (len > 0);
            stall_left = (len > 0) ? len - 1 : 0;
        end
        i_out_stall <= stall_now || (hold_left > 0);
    end

    // Output monitor: compare each accepted byte with the oldest expectation
    always @(posedge i_clk) begin
        t_text_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_text.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: unexpected byte 0x%02h end %0b", $realtime,
                             o_character, o_end_of_run);
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.ch || o_end_of_run !== want.last) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: byte expected 0x%02h end %0b, got 0x%02h end %0b",
                                 $realtime, want.ch, want.last, o_character, o_end_of_run);
                end
            end
        end
    end

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

### filelist.f
hdl/t2a_pkg.sv
hdl/t2a_datapath.sv
hdl/t2a_ctrl.sv
hdl/tenths_to_ascii_formatter.sv
bench/tb_top.sv
